// ===== rtl/ilie_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilie_pkg
// Shared codes, types and defaults for the indexed list with shift-based
// insert and erase.
// ----------------------------------------------------------------------------
package ilie_pkg;

    // Default sizes of the list.
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed field widths of the command and result ports.
    localparam int CMD_W    = 3;
    localparam int POS_W    = 6;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Command codes. Code 7 is unused and is ignored.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_READ   = 3'd5,
        CMD_WRITE  = 3'd6
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_BAD_INDEX = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_READ     = 2'd1,
        ST_SHIFT_UP = 2'd2,
        ST_SHIFT_DN = 2'd3
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/ilie_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilie_ram
// Simple dual-port slot memory: one write port and one read port with a
// registered read. Contents are undefined until written.
// ----------------------------------------------------------------------------
module ilie_ram #(
    parameter int DEPTH = ilie_pkg::DEF_CAPACITY,
    parameter int WIDTH = ilie_pkg::DEF_DATA_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= slot_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/ilie_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilie_ctrl
// Command sequencer and entry counter. Decodes each command, checks it against
// the count, drives the slot memory and moves entries one per cycle for
// insert and erase.
// ----------------------------------------------------------------------------
module ilie_ctrl #(
    parameter int CAPACITY   = ilie_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = ilie_pkg::DEF_DATA_WIDTH,
    parameter int AW         = $clog2(CAPACITY),
    parameter int CW         = $clog2(CAPACITY + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ilie_pkg::CMD_W-1:0]    cmd,
    input  wire logic [ilie_pkg::POS_W-1:0]    position,
    input  wire logic [DATA_WIDTH-1:0]         word,
    output logic                               busy,
    output logic                               done,
    output logic      [DATA_WIDTH-1:0]         result_word,
    output logic      [CW-1:0]                 count,
    output logic      [ilie_pkg::STATUS_W-1:0] status,
    output logic                               mem_we,
    output logic      [AW-1:0]                 mem_waddr,
    output logic      [DATA_WIDTH-1:0]         mem_wdata,
    output logic                               mem_re,
    output logic      [AW-1:0]                 mem_raddr,
    input  wire logic [DATA_WIDTH-1:0]         mem_rdata
);

    // Width wide enough to compare a position against the count.
    localparam int CMPW = (CW > ilie_pkg::POS_W) ? CW : ilie_pkg::POS_W;

    ilie_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              done_reg, done_next;
    logic              pend_reg, pend_next;
    logic [ilie_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic [DATA_WIDTH-1:0] rword_reg, rword_next;

    logic              accept;
    logic              is_full;
    logic              is_empty;
    logic [CMPW-1:0]   pos_cmp;
    logic [CMPW-1:0]   cnt_cmp;
    logic              pos_above;
    logic              pos_at_or_above;
    logic [CW-1:0]     count_dec;
    logic [CW-1:0]     ptr_dec;
    logic              up_reads_left;
    logic              dn_reads_left;

    // Command checks against the current count.
    assign accept          = start && (state_reg == ilie_pkg::ST_IDLE);
    assign is_full         = (count_reg == CW'(CAPACITY));
    assign is_empty        = (count_reg == '0);
    assign pos_cmp         = CMPW'(position);
    assign cnt_cmp         = CMPW'(count_reg);
    assign pos_above       = (pos_cmp > cnt_cmp);
    assign pos_at_or_above = (pos_cmp >= cnt_cmp);
    assign count_dec       = count_reg - CW'(1);
    assign ptr_dec         = ptr_reg - CW'(1);
    assign up_reads_left   = (ptr_reg > CW'(pos_reg));
    assign dn_reads_left   = (ptr_reg < count_reg);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ilie_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        ilie_pkg::CMD_POP:
                        begin
                            if (!is_empty)
                            begin
                                state_next = ilie_pkg::ST_READ;
                            end
                        end
                        ilie_pkg::CMD_INSERT:
                        begin
                            if (!is_full && !pos_above)
                            begin
                                state_next = ilie_pkg::ST_SHIFT_UP;
                            end
                        end
                        ilie_pkg::CMD_ERASE:
                        begin
                            if (!is_empty && !pos_at_or_above)
                            begin
                                state_next = ilie_pkg::ST_SHIFT_DN;
                            end
                        end
                        ilie_pkg::CMD_READ:
                        begin
                            if (!pos_at_or_above)
                            begin
                                state_next = ilie_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ilie_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ilie_pkg::ST_READ:
            begin
                state_next = ilie_pkg::ST_IDLE;
            end
            ilie_pkg::ST_SHIFT_UP:
            begin
                if (!up_reads_left && !pend_reg)
                begin
                    state_next = ilie_pkg::ST_IDLE;
                end
            end
            ilie_pkg::ST_SHIFT_DN:
            begin
                if (!dn_reads_left)
                begin
                    state_next = ilie_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ilie_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory controls and register updates for each state.
    always_comb
    begin
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        count_next     = count_reg;
        done_next      = 1'b0;
        pend_next      = pend_reg;
        status_next    = status_reg;
        ptr_next       = ptr_reg;
        pend_addr_next = pend_addr_reg;
        pos_next       = pos_reg;
        word_next      = word_reg;
        rword_next     = rword_reg;
        case (state_reg)
            ilie_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next    = pos_cmp[AW-1:0];
                    word_next   = word;
                    rword_next  = '0;
                    status_next = ilie_pkg::STAT_OK;
                    pend_next   = 1'b0;
                    case (cmd)
                        ilie_pkg::CMD_PUSH:
                        begin
                            done_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = ilie_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = word;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ilie_pkg::CMD_POP:
                        begin
                            // The vacated slot lies at or above the new count
                            // and is never read again before it is rewritten.
                            if (is_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ilie_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = count_dec[AW-1:0];
                                count_next = count_dec;
                            end
                        end
                        ilie_pkg::CMD_INSERT:
                        begin
                            if (is_full)
                            begin
                                done_next   = 1'b1;
                                status_next = ilie_pkg::STAT_FULL;
                            end
                            else if (pos_above)
                            begin
                                done_next   = 1'b1;
                                status_next = ilie_pkg::STAT_BAD_INDEX;
                            end
                            else
                            begin
                                ptr_next = count_reg;
                            end
                        end
                        ilie_pkg::CMD_ERASE:
                        begin
                            if (is_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ilie_pkg::STAT_EMPTY;
                            end
                            else if (pos_at_or_above)
                            begin
                                done_next   = 1'b1;
                                status_next = ilie_pkg::STAT_BAD_INDEX;
                            end
                            else
                            begin
                                ptr_next = CW'(pos_cmp) + CW'(1);
                            end
                        end
                        ilie_pkg::CMD_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        ilie_pkg::CMD_READ:
                        begin
                            if (pos_at_or_above)
                            begin
                                done_next   = 1'b1;
                                status_next = ilie_pkg::STAT_BAD_INDEX;
                            end
                            else
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = pos_cmp[AW-1:0];
                            end
                        end
                        ilie_pkg::CMD_WRITE:
                        begin
                            done_next = 1'b1;
                            if (pos_at_or_above)
                            begin
                                status_next = ilie_pkg::STAT_BAD_INDEX;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_cmp[AW-1:0];
                                mem_wdata = word;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ilie_pkg::ST_READ:
            begin
                // Read data arrives from the registered read port in the cycle after the address.
                done_next  = 1'b1;
                rword_next = mem_rdata;
            end
            ilie_pkg::ST_SHIFT_UP:
            begin
                // Move entries up from the top down: the word read last cycle
                // lands one place above where it came from.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg + AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (up_reads_left)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = ptr_dec[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_dec[AW-1:0];
                    ptr_next       = ptr_dec;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    // The gap is open: place the new word.
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg;
                    mem_wdata  = word_reg;
                    count_next = count_reg + CW'(1);
                    done_next  = 1'b1;
                end
            end
            ilie_pkg::ST_SHIFT_DN:
            begin
                // Move entries down from the erased place upward: the word
                // read last cycle lands one place below where it came from.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg - AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (dn_reads_left)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = ptr_reg[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[AW-1:0];
                    ptr_next       = ptr_reg + CW'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = count_dec;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ilie_pkg::ST_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            status_reg <= ilie_pkg::STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            pend_reg   <= pend_next;
            status_reg <= status_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        pos_reg       <= pos_next;
        word_reg      <= word_next;
        rword_reg     <= rword_next;
    end

    assign busy        = (state_reg != ilie_pkg::ST_IDLE);
    assign done        = done_reg;
    assign result_word = rword_reg;
    assign count       = count_reg;
    assign status      = status_reg;

endmodule
`default_nettype wire

// ===== rtl/indexed_list_insert_erase.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_erase
// Fixed-capacity ordered list of words with push, pop, insert, erase, clear,
// read and write commands, held in a slot memory.
// ----------------------------------------------------------------------------
// A command transfers at a rising edge where start is high and busy is low.
// Its one result appears on word_out, entry_count and status for exactly one
// cycle with done high, in the cycle after the command finishes; the receiver
// must take it then, as there is no way to hold it. Push, clear, write, every
// rejected command and the unused code finish in the cycle that accepts them;
// pop and read wait for the registered read of the slot memory. Insert and
// erase move the entries behind the index one per cycle through the single
// read and single write port of the memory; insert then places the new word
// in the gap. There is no clearing pass after reset.
module indexed_list_insert_erase #(
    parameter int CAPACITY   = ilie_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = ilie_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ilie_pkg::CMD_W-1:0]    cmd,
    input  wire logic [ilie_pkg::POS_W-1:0]    position,
    input  wire logic [ilie_pkg::WORD_W-1:0]   word_in,
    output logic                               done,
    output logic      [ilie_pkg::WORD_W-1:0]   word_out,
    output logic      [ilie_pkg::COUNT_W-1:0]  entry_count,
    output logic      [ilie_pkg::STATUS_W-1:0] status
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int WW   = (DATA_WIDTH > ilie_pkg::WORD_W) ? DATA_WIDTH : ilie_pkg::WORD_W;
    localparam int CNTW = (CW > ilie_pkg::COUNT_W) ? CW : ilie_pkg::COUNT_W;

    logic [WW-1:0]         word_in_wide;
    logic [DATA_WIDTH-1:0] word_stored;
    logic [DATA_WIDTH-1:0] result_word;
    logic [WW-1:0]         result_wide;
    logic [CW-1:0]         count;
    logic [CNTW-1:0]       count_wide;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    // Fit the incoming word to the stored width.
    assign word_in_wide = WW'(word_in);
    assign word_stored  = word_in_wide[DATA_WIDTH-1:0];

    ilie_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .position    (position),
        .word        (word_stored),
        .busy        (busy),
        .done        (done),
        .result_word (result_word),
        .count       (count),
        .status      (status),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    ilie_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Fit the result word and the count to the port widths.
    assign result_wide = WW'(result_word);
    assign word_out    = result_wide[ilie_pkg::WORD_W-1:0];
    assign count_wide  = CNTW'(count);
    assign entry_count = count_wide[ilie_pkg::COUNT_W-1:0];

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed list with shift-based insert and erase.
// A short table of directed commands walks the empty, edge and error cases,
// and then random bursts fill, drain and mix the list. Every accepted command
// runs through a local model of the list, and each strobed result is checked
// field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import ilie_pkg::*;

    localparam int CAP         = 64;
    localparam int RANDOM_CMDS = 600;
    localparam int DRAIN_WAIT  = 80;
    localparam int CYCLE_LIMIT = 400000;

    // The one command code that the block ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    // Burst flavors of the random part.
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] stat;
    } list_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] word;
        logic              fixed;
        list_result_t      res;
    } list_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    cmd;
    logic [POS_W-1:0]    position;
    logic [WORD_W-1:0]   word_in;
    logic                done;
    logic [WORD_W-1:0]   word_out;
    logic [COUNT_W-1:0]  entry_count;
    logic [STATUS_W-1:0] status;

    // Local copy of the list contents.
    logic [WORD_W-1:0] list_slots [CAP];
    int                list_count;

    list_result_t expected_results [$];
    int           fail_count;
    int           cycle_count;

    indexed_list_insert_erase dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .position   (position),
        .word_in    (word_in),
        .done       (done),
        .word_out   (word_out),
        .entry_count(entry_count),
        .status     (status)
    );

    // Directed commands; rows with fixed set carry an expectation read off by hand.
    list_row_t directed_rows [24] = '{
        '{CMD_POP,    6'd0,  32'h0000_0000, 1'b1, '{32'h0, 7'd0, STAT_EMPTY}},
        '{CMD_ERASE,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 7'd0, STAT_EMPTY}},
        '{CMD_READ,   6'd0,  32'h0000_0000, 1'b1, '{32'h0, 7'd0, STAT_BAD_INDEX}},
        '{CMD_WRITE,  6'd63, 32'hFFFF_FFFF, 1'b1, '{32'h0, 7'd0, STAT_BAD_INDEX}},
        '{CMD_INSERT, 6'd1,  32'hFFFF_FFFF, 1'b1, '{32'h0, 7'd0, STAT_BAD_INDEX}},
        '{CMD_INSERT, 6'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0, 7'd1, STAT_OK}},
        '{CMD_PUSH,   6'd0,  32'h0000_0000, 1'b1, '{32'h0, 7'd2, STAT_OK}},
        '{CMD_PUSH,   6'd63, 32'hA5A5_A5A5, 1'b1, '{32'h0, 7'd3, STAT_OK}},
        '{CMD_INSERT, 6'd3,  32'h5A5A_5A5A, 1'b1, '{32'h0, 7'd4, STAT_OK}},
        '{CMD_INSERT, 6'd1,  32'h1234_5678, 1'b0, '0},
        '{CMD_READ,   6'd0,  32'h0000_0000, 1'b0, '0},
        '{CMD_READ,   6'd4,  32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_WRITE,  6'd2,  32'hDEAD_BEEF, 1'b0, '0},
        '{CMD_READ,   6'd5,  32'h0000_0000, 1'b1, '{32'h0, 7'd5, STAT_BAD_INDEX}},
        '{CMD_ERASE,  6'd0,  32'h0000_0000, 1'b0, '0},
        '{CMD_ERASE,  6'd3,  32'h0000_0000, 1'b0, '0},
        '{CMD_ERASE,  6'd4,  32'h0000_0000, 1'b1, '{32'h0, 7'd3, STAT_BAD_INDEX}},
        '{CMD_POP,    6'd0,  32'h0000_0000, 1'b0, '0},
        '{CMD_UNUSED, 6'd63, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_CLEAR,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 7'd0, STAT_OK}},
        '{CMD_POP,    6'd0,  32'h0000_0000, 1'b1, '{32'h0, 7'd0, STAT_EMPTY}},
        '{CMD_INSERT, 6'd63, 32'h0000_0000, 1'b1, '{32'h0, 7'd0, STAT_BAD_INDEX}},
        '{CMD_PUSH,   6'd0,  32'h8000_0001, 1'b1, '{32'h0, 7'd1, STAT_OK}},
        '{CMD_READ,   6'd0,  32'h0000_0000, 1'b1, '{32'h8000_0001, 7'd1, STAT_OK}}
    };

    // Free-running clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Applies one command to the local list and returns the result it should give.
    function automatic list_result_t apply_list_cmd(logic [CMD_W-1:0] op,
                                                    logic [POS_W-1:0] pos,
                                                    logic [WORD_W-1:0] word);
        list_result_t res;
        int           i;
        res = '{word: '0, count: '0, stat: STAT_OK};
        case (op)
            CMD_PUSH:
                if (list_count >= CAP) res.stat = STAT_FULL;
                else
                begin
                    list_slots[list_count] = word;
                    list_count++;
                end
            CMD_POP:
                if (list_count == 0) res.stat = STAT_EMPTY;
                else
                begin
                    list_count--;
                    res.word = list_slots[list_count];
                    list_slots[list_count] = '0;
                end
            CMD_INSERT:
                if (list_count >= CAP) res.stat = STAT_FULL;
                else if (int'(pos) > list_count) res.stat = STAT_BAD_INDEX;
                else
                begin
                    for (i = list_count; i > int'(pos); i--)
                        list_slots[i] = list_slots[i-1];
                    list_slots[pos] = word;
                    list_count++;
                end
            CMD_ERASE:
                if (list_count == 0) res.stat = STAT_EMPTY;
                else if (int'(pos) >= list_count) res.stat = STAT_BAD_INDEX;
                else
                begin
                    for (i = int'(pos); i + 1 < list_count; i++)
                        list_slots[i] = list_slots[i+1];
                    list_count--;
                end
            CMD_CLEAR:
                list_count = 0;
            CMD_READ:
                if (int'(pos) >= list_count) res.stat = STAT_BAD_INDEX;
                else res.word = list_slots[pos];
            CMD_WRITE:
                if (int'(pos) >= list_count) res.stat = STAT_BAD_INDEX;
                else list_slots[pos] = word;
            default: ;
        endcase
        res.count = COUNT_W'(list_count);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $realtime, msg);
        fail_count++;
    endtask

    // Holds one command on the inputs until it transfers, then sometimes idles for a while.
    task automatic send_list_cmd(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                                 input logic [WORD_W-1:0] word, input logic fixed,
                                 input list_result_t fixed_res);
        list_result_t res;
        int           r;
        int           gap;
        start    <= 1'b1;
        cmd      <= op;
        position <= pos;
        word_in  <= word;
        do @(posedge clk); while (busy);
        res = apply_list_cmd(op, pos, word);
        if (fixed) res = fixed_res;
        expected_results = {expected_results, res};

        // Mostly back to back or short gaps, now and then a long one.
        r = $urandom_range(0, 99);
        if (r < 55) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [POS_W-1:0] held_index();
        return (list_count > 0) ? POS_W'($urandom_range(0, list_count - 1)) : '0;
    endfunction

    function automatic logic [POS_W-1:0] index_from(int lo);
        return (lo <= CAP - 1) ? POS_W'($urandom_range(lo, CAP - 1))
                               : POS_W'($urandom_range(0, CAP - 1));
    endfunction

    // Picks one random command, shaped by the flavor of the current burst.
    task automatic pick_list_cmd(input int mode, output logic [CMD_W-1:0] op,
                                 output logic [POS_W-1:0] pos,
                                 output logic [WORD_W-1:0] word);
        int r;
        int insert_top;
        r = $urandom_range(0, 9);
        word = (r == 0) ? '0 : (r == 1) ? '1 : WORD_W'($urandom());
        insert_top = (list_count < CAP) ? list_count : CAP - 1;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                if (r < 45)
                begin
                    op  = CMD_PUSH;
                    pos = POS_W'($urandom());
                end
                else if (r < 85)
                begin
                    op  = CMD_INSERT;
                    pos = POS_W'($urandom_range(0, insert_top));
                end
                else if (r < 95)
                begin
                    op  = (r < 90) ? CMD_WRITE : CMD_READ;
                    pos = held_index();
                end
                else
                begin
                    op  = CMD_INSERT;
                    pos = index_from(list_count + 1);
                end
            end
            MODE_DRAIN:
            begin
                if (r < 40)
                begin
                    op  = CMD_POP;
                    pos = POS_W'($urandom());
                end
                else if (r < 80)
                begin
                    op  = CMD_ERASE;
                    pos = held_index();
                end
                else if (r < 92)
                begin
                    op  = CMD_READ;
                    pos = held_index();
                end
                else
                begin
                    op  = (r < 96) ? CMD_ERASE : CMD_READ;
                    pos = index_from(list_count);
                end
            end
            default:
            begin
                op = CMD_W'($urandom_range(0, 7));
                if (op == CMD_CLEAR && $urandom_range(0, 3) != 0) op = CMD_READ;
                if (r < 80)
                    pos = (op == CMD_INSERT) ? POS_W'($urandom_range(0, insert_top))
                                             : held_index();
                else
                    pos = POS_W'($urandom());
            end
        endcase
    endtask

    // Result checker: each strobed result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        list_result_t exp_res;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result transfer with no command pending");
            else
            begin
                exp_res = expected_results.pop_front();
                if (word_out !== exp_res.word)
                    report_mismatch($sformatf("word_out %h, expected %h",
                                              word_out, exp_res.word));
                if (entry_count !== exp_res.count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              entry_count, exp_res.count));
                if (status !== exp_res.stat)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, exp_res.stat));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic [CMD_W-1:0]  op;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] word;
        int                mode;
        int                burst_len;
        int                sent;
        fail_count  = 0;
        cycle_count = 0;
        list_count  = 0;
        foreach (list_slots[i]) list_slots[i] = '0;
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = '0;
        position = '0;
        word_in  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed_rows[i])
            send_list_cmd(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].word,
                          directed_rows[i].fixed, directed_rows[i].res);

        // Random bursts that fill the list, drain it, or mix everything.
        sent = 0;
        while (sent < RANDOM_CMDS)
        begin
            mode      = $urandom_range(MODE_FILL, MODE_MIX);
            burst_len = (mode == MODE_FILL) ? $urandom_range(30, 90) : $urandom_range(10, 50);
            repeat (burst_len)
            begin
                pick_list_cmd(mode, op, pos, word);
                send_list_cmd(op, pos, word, 1'b0, '0);
                sent++;
            end
        end
        start <= 1'b0;

        // Let every pending result come back, then watch for stray strobes.
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
